### rtl/core/edf_next_job_selector_assert.svh
`ifndef EDF_NEXT_JOB_SELECTOR_ASSERT_SVH
`define EDF_NEXT_JOB_SELECTOR_ASSERT_SVH

// same-cycle implication
`define EDF_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define EDF_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/edf_sel_pkg.sv
package edf_sel_pkg;

   localparam int OP_W       = 2;
   localparam int IDX_PORT_W = 6;
   localparam int TIME_W     = 32;
   localparam int CNT_PORT_W = 7;
   localparam int SLOT_LIMIT = 2 ** IDX_PORT_W;

   localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
   localparam logic [OP_W-1:0] OP_RETIRE = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   typedef struct packed {
      logic load;
      logic retire;
      logic start;
      logic scan;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic limit_zero;
      logic last_issue;
      logic out_free;
   } sts_type;

endpackage

### rtl/core/edf_sel_ram.sv
module edf_sel_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/edf_sel_ctrl.sv
module edf_sel_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [edf_sel_pkg::OP_W-1:0] req_operation,
   input  edf_sel_pkg::sts_type        sts,
   output edf_sel_pkg::cmd_type        cmd
);

   import edf_sel_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               unique case (req_operation)
                  OP_LOAD:   cmd.load = 1'b1;
                  OP_RETIRE: cmd.retire = 1'b1;
                  OP_QUERY: begin
                     cmd.start = 1'b1;
                     state_in  = sts.limit_zero ? ST_FINISH : ST_SCAN;
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.last_issue) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_FINISH;
         ST_FINISH: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/core/edf_sel_dp.sv
module edf_sel_dp #(
   parameter int MAX_JOBS  = 64,
   parameter int TIME_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  edf_sel_pkg::cmd_type              cmd,
   output edf_sel_pkg::sts_type              sts,
   input  logic [edf_sel_pkg::IDX_PORT_W-1:0] req_job_index,
   input  logic [edf_sel_pkg::TIME_W-1:0]     req_release_time,
   input  logic [edf_sel_pkg::TIME_W-1:0]     req_deadline_time,
   input  logic [edf_sel_pkg::TIME_W-1:0]     req_query_time,
   input  logic                              csr_we,
   input  logic [edf_sel_pkg::CNT_PORT_W-1:0] csr_wdata,
   input  logic                              rsp_stall,
   output logic                              rsp_valid,
   output logic                              rsp_found,
   output logic [edf_sel_pkg::IDX_PORT_W-1:0] rsp_selected_job
);

   import edf_sel_pkg::*;

   // only the first SLOT_LIMIT entries are reachable through the index field
   localparam int JOB_SLOTS = (MAX_JOBS < SLOT_LIMIT) ? MAX_JOBS : SLOT_LIMIT;
   localparam int ADDR_W    = $clog2(JOB_SLOTS);
   localparam int CNT_W     = $clog2(JOB_SLOTS + 1);

   logic [CNT_PORT_W-1:0]  count_ff;
   logic [CNT_W-1:0]       limit_w;
   logic                   idx_ok;
   logic [ADDR_W-1:0]      slot;
   logic [JOB_SLOTS-1:0]   done_ff;
   logic [ADDR_W-1:0]      scan_ff;
   logic [TIME_BITS-1:0]   now_ff;
   logic [2*TIME_BITS-1:0] rd_data;

   logic                   pv_ff;
   logic                   p_done_ff;
   logic [ADDR_W-1:0]      p_idx_ff;

   logic                   early_ff;
   logic                   have_e_ff;
   logic                   have_a_ff;
   logic [TIME_BITS-1:0]   best_e_d_ff;
   logic [ADDR_W-1:0]      best_e_i_ff;
   logic [TIME_BITS-1:0]   best_a_r_ff;
   logic [TIME_BITS-1:0]   best_a_d_ff;
   logic [ADDR_W-1:0]      best_a_i_ff;

   logic [TIME_BITS-1:0]   cur_r;
   logic [TIME_BITS-1:0]   cur_d;
   logic                   hit_early;
   logic                   take_e;
   logic                   take_a;

   logic                   rsp_valid_ff;
   logic                   rsp_found_ff;
   logic [IDX_PORT_W-1:0]  rsp_job_ff;
   logic                   fin_found;
   logic [ADDR_W-1:0]      fin_idx;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_we) begin
         count_ff <= csr_wdata;
      end
   end

   always_comb begin
      if (count_ff > CNT_PORT_W'(JOB_SLOTS)) begin
         limit_w = CNT_W'(JOB_SLOTS);
      end else begin
         limit_w = CNT_W'(count_ff);
      end
   end

   assign idx_ok = int'(req_job_index) < JOB_SLOTS;
   assign slot   = ADDR_W'(req_job_index);

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= '1;
      end else if (idx_ok) begin
         if (cmd.load) begin
            done_ff[slot] <= 1'b0;
         end else if (cmd.retire) begin
            done_ff[slot] <= 1'b1;
         end
      end
   end

   edf_sel_ram #(
      .WIDTH (2 * TIME_BITS),
      .DEPTH (JOB_SLOTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.load && idx_ok),
      .wr_addr (slot),
      .wr_data ({TIME_BITS'(req_release_time), TIME_BITS'(req_deadline_time)}),
      .rd_addr (scan_ff),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         scan_ff <= '0;
         now_ff  <= TIME_BITS'(req_query_time);
      end else if (cmd.scan) begin
         scan_ff <= scan_ff + ADDR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
      end else begin
         pv_ff <= cmd.scan;
      end
   end

   always_ff @(posedge clock) begin
      p_idx_ff  <= scan_ff;
      p_done_ff <= done_ff[scan_ff];
   end

   assign cur_r = rd_data[2*TIME_BITS-1:TIME_BITS];
   assign cur_d = rd_data[TIME_BITS-1:0];

   always_comb begin
      hit_early = pv_ff && !p_done_ff && (cur_r < now_ff);
      take_e    = pv_ff && !p_done_ff && (cur_r <= now_ff) &&
                  (!have_e_ff || (cur_d < best_e_d_ff));
      take_a    = pv_ff && !p_done_ff &&
                  (!have_a_ff || (cur_r < best_a_r_ff) ||
                   ((cur_r == best_a_r_ff) && (cur_d < best_a_d_ff)));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         early_ff  <= 1'b0;
         have_e_ff <= 1'b0;
         have_a_ff <= 1'b0;
      end else if (cmd.start) begin
         early_ff  <= 1'b0;
         have_e_ff <= 1'b0;
         have_a_ff <= 1'b0;
      end else begin
         if (hit_early) begin
            early_ff <= 1'b1;
         end
         if (take_e) begin
            have_e_ff <= 1'b1;
         end
         if (take_a) begin
            have_a_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take_e) begin
         best_e_d_ff <= cur_d;
         best_e_i_ff <= p_idx_ff;
      end
      if (take_a) begin
         best_a_r_ff <= cur_r;
         best_a_d_ff <= cur_d;
         best_a_i_ff <= p_idx_ff;
      end
   end

   always_comb begin
      if (early_ff) begin
         fin_found = 1'b1;
         fin_idx   = best_e_i_ff;
      end else begin
         fin_found = have_a_ff;
         fin_idx   = have_a_ff ? best_a_i_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_found_ff <= fin_found;
         rsp_job_ff   <= IDX_PORT_W'(fin_idx);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_selected_job = rsp_job_ff;

   assign sts.limit_zero = (limit_w == '0);
   assign sts.last_issue = ((CNT_W'(scan_ff) + CNT_W'(1)) == limit_w);
   assign sts.out_free   = !rsp_valid_ff || !rsp_stall;

endmodule

### rtl/core/edf_next_job_selector.sv
// channel   ports                              word
// req       req_valid / req_stall              operation, index, release, deadline, query tick
// rsp       rsp_valid / rsp_stall              found, selected job (queries only)
// csr       csr_we / csr_wdata                 job_count
//
// Load, retire and unused codes complete without leaving the idle state.
// A query scans min(job_count, table size) entries, or goes straight to its last state when that is zero:
// one entry per cycle through the store's registered read port into one compare stage.
// Reset marks every entry done; no clearing pass.
// The result sits in an output register; a new item is taken while it waits.
// A finished query holds in its last state while the output register is full and stalled.
module edf_next_job_selector #(
   parameter int MAX_JOBS  = 64,
   parameter int TIME_BITS = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [edf_sel_pkg::OP_W-1:0]       req_operation,
   input  logic [edf_sel_pkg::IDX_PORT_W-1:0] req_job_index,
   input  logic [edf_sel_pkg::TIME_W-1:0]     req_release_time,
   input  logic [edf_sel_pkg::TIME_W-1:0]     req_deadline_time,
   input  logic [edf_sel_pkg::TIME_W-1:0]     req_query_time,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_found,
   output logic [edf_sel_pkg::IDX_PORT_W-1:0] rsp_selected_job,
   input  logic                               csr_we,
   input  logic [edf_sel_pkg::CNT_PORT_W-1:0] csr_wdata
);

   import edf_sel_pkg::*;

   cmd_type cmd;
   sts_type sts;

   edf_sel_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .sts           (sts),
      .cmd           (cmd)
   );

   edf_sel_dp #(
      .MAX_JOBS  (MAX_JOBS),
      .TIME_BITS (TIME_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_job_index     (req_job_index),
      .req_release_time  (req_release_time),
      .req_deadline_time (req_deadline_time),
      .req_query_time    (req_query_time),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_found         (rsp_found),
      .rsp_selected_job  (rsp_selected_job)
   );

endmodule

### rtl/core/edf_next_job_selector_chk.sv
`include "edf_next_job_selector_assert.svh"

module edf_next_job_selector_chk (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input logic [edf_sel_pkg::OP_W-1:0]       req_operation,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic                               rsp_found,
   input logic [edf_sel_pkg::IDX_PORT_W-1:0] rsp_selected_job
);

   import edf_sel_pkg::*;

   `EDF_ASSERT_NXT(a_query_holds_input, clock, reset, req_valid && !req_stall && (req_operation == OP_QUERY), req_stall, "query word did not hold off the input")
   `EDF_ASSERT_IMP(a_rsp_after_busy, clock, reset, $rose(rsp_valid), $past(req_stall), "result appeared without a query in flight")
   `EDF_ASSERT_IMP(a_miss_index_zero, clock, reset, rsp_valid && !rsp_found, rsp_selected_job == '0, "not-found result carries a nonzero index")
   `EDF_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_found) && $stable(rsp_selected_job), "stalled result word changed")

endmodule

bind edf_next_job_selector edf_next_job_selector_chk u_chk (.*);
